// File: hw/rtl/srt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the session route table
// Holds the table size, the command and entry layouts and the back-end
// state encoding.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int MAX_SESSIONS = 16;
    localparam int CNT_W        = $clog2(MAX_SESSIONS + 1);
    localparam int IDX_W        = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;

    typedef enum logic [1:0] {
        OP_ROUTE  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               exact;
        logic [15:0]        bare;
        logic [7:0]         res;
        logic signed [7:0]  prio;
        logic [7:0]         tag;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        bare;
        logic [7:0]         res;
        logic signed [7:0]  prio;
        logic [7:0]         tag;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUTE,
        ST_REMOVE
    } t_state;

endpackage

// File: hw/rtl/srt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_front: request intake and command queue
// Accepts request transfers, decodes the operation and flags exact-resource
// requests, and holds up to two commands for the back end.
// ----------------------------------------------------------------------------
module srt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_op,
    input  logic [15:0]         i_bare_id,
    input  logic [7:0]          i_resource_id,
    input  logic signed [7:0]   i_priority_req,
    input  logic [7:0]          i_session_tag,
    output logic                o_cmd_valid,
    output srt_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_ready
);
    import srt_pkg::*;

    t_cmd       r_fifo [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic [1:0] n_level;
    t_cmd       n_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        n_cmd.op    = t_op'(i_op);
        n_cmd.exact = (i_resource_id != 8'd0);
        n_cmd.bare  = i_bare_id;
        n_cmd.res   = i_resource_id;
        n_cmd.prio  = i_priority_req;
        n_cmd.tag   = i_session_tag;
    end

    assign o_ready     = (r_level != 2'd2);
    assign o_cmd_valid = (r_level != 2'd0);
    assign o_cmd       = r_fifo[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_level = r_level;
        if (push && !pop) begin
            n_level = r_level + 2'd1;
        end else if (pop && !push) begin
            n_level = r_level - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            r_level <= n_level;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_cmd;
        end
    end

endmodule

// File: hw/rtl/srt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_back: session table and command execution
// Holds the ordered session table, appends on add, closes up one removed
// entry per cycle, scans one entry per cycle on route and registers results.
// ----------------------------------------------------------------------------
module srt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  srt_pkg::t_cmd       i_cmd,
    output logic                o_cmd_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_delivered,
    output logic [7:0]          o_target_tag,
    output logic                o_table_full
);
    import srt_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_entry             r_entry [MAX_SESSIONS];
    logic [CNT_W-1:0]   r_count;
    t_cmd               r_req;
    logic [CNT_W-1:0]   r_idx;
    logic               r_found;
    logic signed [7:0]  r_best;
    logic [7:0]         r_best_tag;
    logic               r_exact_found;
    logic [7:0]         r_exact_tag;
    logic               r_out_valid;
    logic               r_out_delivered;
    logic [7:0]         r_out_tag;
    logic               r_out_full;

    logic               out_free;
    logic               cmd_pop;
    logic               load_req;
    logic               add_write;
    logic               scan_step;
    logic               shift_en;
    logic               res_load;
    logic               res_delivered;
    logic [7:0]         res_tag;
    logic               res_full;
    logic               table_has_room;
    logic               scan_active;
    t_entry             ent;
    logic               ent_bare_hit;
    logic               ent_exact;
    logic               ent_better;
    logic [MAX_SESSIONS-1:0] rm_hit;
    logic               rm_any;
    logic [IDX_W-1:0]   rm_idx;

    assign out_free       = !r_out_valid || i_ready;
    assign table_has_room = (r_count < CNT_W'(MAX_SESSIONS));
    assign scan_active    = (r_idx < r_count);
    assign ent            = r_entry[r_idx[IDX_W-1:0]];
    assign ent_bare_hit   = (ent.bare == r_req.bare);
    assign ent_exact      = r_req.exact && ent_bare_hit && (ent.res == r_req.res);
    assign ent_better     = ent_bare_hit && !ent.prio[7] && (!r_found || (ent.prio > r_best));

    always_comb begin
        for (int i = 0; i < MAX_SESSIONS; i++) begin
            rm_hit[i] = (CNT_W'(i) < r_count) && (r_entry[i].tag == r_req.tag);
        end
        rm_any = |rm_hit;
        rm_idx = '0;
        for (int i = MAX_SESSIONS - 1; i >= 0; i--) begin
            if (rm_hit[i]) begin
                rm_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_pop && (i_cmd.op == OP_ROUTE)) begin
                    n_state = ST_ROUTE;
                end else if (cmd_pop && (i_cmd.op == OP_REMOVE)) begin
                    n_state = ST_REMOVE;
                end
            end
            ST_ROUTE: begin
                if (!scan_active && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REMOVE: begin
                if (!rm_any && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop       = 1'b0;
        load_req      = 1'b0;
        add_write     = 1'b0;
        scan_step     = 1'b0;
        shift_en      = 1'b0;
        res_load      = 1'b0;
        res_delivered = 1'b0;
        res_tag       = 8'd0;
        res_full      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                cmd_pop = i_cmd_valid && out_free;
                if (cmd_pop) begin
                    unique case (i_cmd.op)
                        OP_ADD: begin
                            add_write = table_has_room;
                            res_load  = 1'b1;
                            res_full  = !table_has_room;
                        end
                        OP_NOP: begin
                            res_load = 1'b1;
                        end
                        OP_ROUTE, OP_REMOVE: begin
                            load_req = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROUTE: begin
                if (scan_active) begin
                    scan_step = 1'b1;
                end else if (out_free) begin
                    res_load = 1'b1;
                    if (r_exact_found) begin
                        res_delivered = 1'b1;
                        res_tag       = r_exact_tag;
                    end else if (r_found) begin
                        res_delivered = 1'b1;
                        res_tag       = r_best_tag;
                    end
                end
            end
            ST_REMOVE: begin
                if (rm_any) begin
                    shift_en = 1'b1;
                end else if (out_free) begin
                    res_load = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_cmd_ready = cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_idx         <= '0;
            r_found       <= 1'b0;
            r_exact_found <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (add_write) begin
                r_count <= r_count + CNT_W'(1);
            end else if (shift_en) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (load_req) begin
                r_idx         <= '0;
                r_found       <= 1'b0;
                r_exact_found <= 1'b0;
            end else if (scan_step) begin
                r_idx <= r_idx + CNT_W'(1);
                if (ent_better) begin
                    r_found <= 1'b1;
                end
                if (ent_exact) begin
                    r_exact_found <= 1'b1;
                end
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_req) begin
            r_req <= i_cmd;
        end
        if (scan_step && ent_better) begin
            r_best     <= ent.prio;
            r_best_tag <= ent.tag;
        end
        if (scan_step && ent_exact && !r_exact_found) begin
            r_exact_tag <= ent.tag;
        end
        if (res_load) begin
            r_out_delivered <= res_delivered;
            r_out_tag       <= res_tag;
            r_out_full      <= res_full;
        end
        if (add_write) begin
            r_entry[r_count[IDX_W-1:0]] <= '{bare: i_cmd.bare, res: i_cmd.res,
                                             prio: i_cmd.prio, tag: i_cmd.tag};
        end
        if (shift_en) begin
            for (int j = 0; j < MAX_SESSIONS - 1; j++) begin
                if (IDX_W'(j) >= rm_idx) begin
                    r_entry[j] <= r_entry[j + 1];
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_delivered  = r_out_delivered;
    assign o_target_tag = r_out_tag;
    assign o_table_full = r_out_full;

endmodule

// File: hw/rtl/session_route_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_route_table: ordered client session table with routing
// Commands pass through the front-end queue to the back end, which registers
// each result. Route scans one table entry per cycle; remove does one close-up
// shift per cycle, one per removed entry.
// Throughput: add and no-op one item per cycle while results are taken; route
// and remove hold the back end until done; the queue overlaps intake.
// Reset: synchronous active low; empties the table and queue, no sweep.
// ----------------------------------------------------------------------------
module session_route_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_op,
    input  logic [15:0]         i_bare_id,
    input  logic [7:0]          i_resource_id,
    input  logic signed [7:0]   i_priority_req,
    input  logic [7:0]          i_session_tag,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_delivered,
    output logic [7:0]          o_target_tag,
    output logic                o_table_full
);
    import srt_pkg::*;

    logic   cmd_valid;
    logic   cmd_ready;
    t_cmd   cmd;

    srt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_bare_id      (i_bare_id),
        .i_resource_id  (i_resource_id),
        .i_priority_req (i_priority_req),
        .i_session_tag  (i_session_tag),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_ready    (cmd_ready)
    );

    srt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_ready    (cmd_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_delivered    (o_delivered),
        .o_target_tag   (o_target_tag),
        .o_table_full   (o_table_full)
    );

endmodule

// File: tb/tb_session_route_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_session_route_table: self-checking bench for the session route table
// Mirrors the session table in a scoreboard, predicts the outcome of every
// route, add, remove and no-op, and compares each result transfer with the
// oldest prediction. A directed opening is followed by random traffic with
// idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_session_route_table;
    import srt_pkg::*;

    typedef struct {
        logic       delivered;
        logic [7:0] target_tag;
        logic       table_full;
    } t_outcome;

    class session_table_tracker;
        logic [15:0]       bare_q[MAX_SESSIONS];
        logic [7:0]        res_q[MAX_SESSIONS];
        logic signed [7:0] prio_q[MAX_SESSIONS];
        logic [7:0]        tag_q[MAX_SESSIONS];
        int                entry_count;
        t_outcome          pending_outcomes[$];
        int                mismatches;
        int                n_route, n_delivered, n_add, n_dropped, n_remove, n_nop;

        function new();
            entry_count = 0;
            mismatches  = 0;
            n_route = 0; n_delivered = 0; n_add = 0;
            n_dropped = 0; n_remove = 0; n_nop = 0;
        endfunction

        function void note_request(t_op op, logic [15:0] bare, logic [7:0] res,
                                   logic signed [7:0] prio, logic [7:0] tag);
            t_outcome o;
            bit       hit;
            bit       found;
            int       best;
            int       pick;
            int       p;
            int       w;
            o.delivered  = 1'b0;
            o.target_tag = 8'd0;
            o.table_full = 1'b0;
            case (op)
                OP_ROUTE: begin
                    n_route++;
                    hit = 0;
                    if (res != 8'd0) begin
                        for (int i = 0; i < entry_count; i++) begin
                            if (!hit && bare_q[i] == bare && res_q[i] == res) begin
                                hit = 1;
                                o.delivered  = 1'b1;
                                o.target_tag = tag_q[i];
                            end
                        end
                    end
                    if (!hit) begin
                        found = 0;
                        best  = 0;
                        pick  = 0;
                        for (int i = 0; i < entry_count; i++) begin
                            p = prio_q[i];
                            if (bare_q[i] == bare && p >= 0 && (!found || p > best)) begin
                                found = 1;
                                best  = p;
                                pick  = i;
                            end
                        end
                        if (found) begin
                            o.delivered  = 1'b1;
                            o.target_tag = tag_q[pick];
                        end
                    end
                    if (o.delivered) n_delivered++;
                end
                OP_ADD: begin
                    n_add++;
                    if (entry_count < MAX_SESSIONS) begin
                        bare_q[entry_count] = bare;
                        res_q[entry_count]  = res;
                        prio_q[entry_count] = prio;
                        tag_q[entry_count]  = tag;
                        entry_count++;
                    end else begin
                        o.table_full = 1'b1;
                        n_dropped++;
                    end
                end
                OP_REMOVE: begin
                    n_remove++;
                    w = 0;
                    for (int i = 0; i < entry_count; i++) begin
                        if (tag_q[i] != tag) begin
                            bare_q[w] = bare_q[i];
                            res_q[w]  = res_q[i];
                            prio_q[w] = prio_q[i];
                            tag_q[w]  = tag_q[i];
                            w++;
                        end
                    end
                    entry_count = w;
                end
                default: n_nop++;
            endcase
            pending_outcomes = {pending_outcomes, o};
        endfunction

        function void check_result(logic delivered, logic [7:0] target_tag,
                                   logic table_full);
            t_outcome e;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result: delivered=%b tag=%h full=%b",
                             $time, delivered, target_tag, table_full);
                return;
            end
            e = pending_outcomes.pop_front();
            if (delivered !== e.delivered || target_tag !== e.target_tag ||
                table_full !== e.table_full) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected dlv=%b tag=%h full=%b, got dlv=%b tag=%h full=%b",
                             $time, e.delivered, e.target_tag, e.table_full,
                             delivered, target_tag, table_full);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_op;
    logic [15:0]       i_bare_id;
    logic [7:0]        i_resource_id;
    logic signed [7:0] i_priority_req;
    logic [7:0]        i_session_tag;
    logic              o_valid;
    logic              i_ready;
    logic              o_delivered;
    logic [7:0]        o_target_tag;
    logic              o_table_full;

    session_table_tracker sb;
    bit                   steady;
    logic [15:0]          bare_pool[4] = '{16'h0001, 16'h8000, 16'hFFFE, 16'h7F3C};

    session_route_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_bare_id      (i_bare_id),
        .i_resource_id  (i_resource_id),
        .i_priority_req (i_priority_req),
        .i_session_tag  (i_session_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_delivered    (o_delivered),
        .o_target_tag   (o_target_tag),
        .o_table_full   (o_table_full)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_valid && o_ready)
                sb.note_request(t_op'(i_op), i_bare_id, i_resource_id,
                                i_priority_req, i_session_tag);
            if (o_valid && i_ready)
                sb.check_result(o_delivered, o_target_tag, o_table_full);
        end
    end

    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!steady && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    task automatic send_item(t_op op, logic [15:0] bare, logic [7:0] res,
                             logic signed [7:0] prio, logic [7:0] tag);
        if (!steady && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_bare_id      <= bare;
        i_resource_id  <= res;
        i_priority_req <= prio;
        i_session_tag  <= tag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int          r;
        int          k;
        t_op         op;
        logic [15:0] bare;
        logic [7:0]  res;
        logic [7:0]  prio;
        logic [7:0]  tag;
        r    = $urandom_range(0, 99);
        bare = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                           : bare_pool[$urandom_range(0, 3)];
        res  = ($urandom_range(0, 2) == 0) ? 8'd0 :
               ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 4)) : 8'($urandom);
        prio = ($urandom_range(0, 4) < 2) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        tag  = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        if (r < 5)
            op = OP_NOP;
        else if (r < 45)
            op = OP_ROUTE;
        else if ($urandom_range(0, MAX_SESSIONS + 2) >= sb.entry_count)
            op = OP_ADD;
        else
            op = OP_REMOVE;
        if (sb.entry_count > 0) begin
            k = $urandom_range(0, sb.entry_count - 1);
            if (op == OP_ROUTE && $urandom_range(0, 4) != 0) begin
                bare = sb.bare_q[k];
                if ($urandom_range(0, 1) == 0) res = sb.res_q[k];
            end
            if (op == OP_REMOVE && $urandom_range(0, 9) < 7) tag = sb.tag_q[k];
        end
        if (op == OP_NOP) begin
            bare = 16'($urandom);
            res  = 8'($urandom);
            tag  = 8'($urandom);
            prio = 8'($urandom);
        end
        send_item(op, bare, res, prio, tag);
    endtask

    initial begin
        sb             = new();
        steady         = 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_op           <= OP_NOP;
        i_bare_id      <= 16'd0;
        i_resource_id  <= 8'd0;
        i_priority_req <= 8'sd0;
        i_session_tag  <= 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: empty table, field extremes, exact and fallback
        // routing, duplicate tags, an absent remove, then fill past the limit.
        send_item(OP_ROUTE,  16'h0000, 8'h00, 8'sd0,    8'h00);
        send_item(OP_ADD,    16'hFFFF, 8'hFF, -8'sd128, 8'hFF);
        send_item(OP_ADD,    16'hFFFF, 8'h01, 8'sd127,  8'h00);
        send_item(OP_ADD,    16'hFFFF, 8'h80, 8'sd0,    8'h55);
        send_item(OP_ROUTE,  16'hFFFF, 8'hFF, 8'sd0,    8'h00);
        send_item(OP_ROUTE,  16'hFFFF, 8'h22, 8'sd0,    8'h00);
        send_item(OP_ADD,    16'h0000, 8'h00, -8'sd1,   8'hAA);
        send_item(OP_ROUTE,  16'h0000, 8'h00, 8'sd0,    8'h00);
        send_item(OP_ADD,    16'hFFFF, 8'h02, 8'sd127,  8'h00);
        send_item(OP_ROUTE,  16'hFFFF, 8'h00, -8'sd1,   8'hFF);
        send_item(OP_NOP,    16'hFFFF, 8'hFF, -8'sd1,   8'hFF);
        send_item(OP_REMOVE, 16'h0000, 8'h00, 8'sd0,    8'h33);
        send_item(OP_REMOVE, 16'h0000, 8'h00, 8'sd0,    8'h00);
        send_item(OP_ROUTE,  16'hFFFF, 8'h00, 8'sd0,    8'h00);
        while (sb.entry_count < MAX_SESSIONS)
            send_item(OP_ADD, 16'(sb.entry_count), 8'(sb.entry_count),
                      8'(sb.entry_count), 8'(sb.entry_count));
        send_item(OP_ADD,    16'h1234, 8'h01, 8'sd5,    8'h01);
        send_item(OP_ROUTE,  16'h0005, 8'h00, 8'sd0,    8'h00);

        for (int n = 0; n < 1900; n++) begin
            if (n == 1600) steady = 1'b1;
            send_random_item();
        end
        i_valid <= 1'b0;

        while (sb.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d routes (%0d delivered), %0d adds (%0d dropped when full),",
                 sb.n_route, sb.n_delivered, sb.n_add, sb.n_dropped);
        $display("%0d removes and %0d no-ops, with %0d mismatches.",
                 sb.n_remove, sb.n_nop, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/srt_pkg.sv
hw/rtl/srt_front.sv
hw/rtl/srt_back.sv
hw/rtl/session_route_table.sv
tb/tb_session_route_table.sv
